[sv/ddg_pkg.sv]
// Package: shared types, constants and helpers for the DDA grid ray walk.
`timescale 1ns / 1ps
package ddg_pkg;

    // Walk length per ray, clamped to 1..64
    localparam int MAX_STEPS  = 32;
    localparam int STEPS      = (MAX_STEPS < 1) ? 1 : ((MAX_STEPS > 64) ? 64 : MAX_STEPS);
    localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

    // Grid square size and divider geometry: quotient of 2^20 by a 16-bit magnitude
    localparam int SQ_SHIFT   = 10;
    localparam int DIV_CELLS  = 21;
    localparam int QUO_W      = DIV_CELLS;
    localparam int REM_W      = 16;
    localparam int SD_W       = 28;
    localparam int DIST_W     = 27;
    localparam int PROD_W     = DIST_W + 1 + 16;

    // Face codes
    localparam logic [1:0] FACE_Y_NEG = 2'd0;
    localparam logic [1:0] FACE_X_NEG = 2'd1;
    localparam logic [1:0] FACE_Y_POS = 2'd2;
    localparam logic [1:0] FACE_X_POS = 2'd3;

    typedef struct packed {
        logic        [19:0] start_x;
        logic        [19:0] start_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } ray_t;

    typedef struct packed {
        logic signed [11:0] cell_x;
        logic signed [11:0] cell_y;
        logic        [25:0] distance;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic        [1:0]  face;
        logic        [9:0]  tex_coord;
        logic               last;
    } result_t;

    // State of one divider cell, handed down the chain every cycle
    typedef struct packed {
        logic               valid;
        ray_t               ray;
        logic [REM_W-1:0]   rem_x;
        logic [REM_W-1:0]   rem_y;
        logic [QUO_W-1:0]   quo_x;
        logic [QUO_W-1:0]   quo_y;
    } div_cell_t;

    // Divisor magnitude; a zero component counts as one
    function automatic logic [15:0] div_mag(input logic signed [15:0] d);
        logic [15:0] m;
        m = 16'(-d);
        if (d == 16'sd0)
            return 16'd1;
        else if (d < 16'sd0)
            return m;
        else
            return d;
    endfunction

endpackage

[sv/ddg_div_cell.sv]
// Divider cell: one restoring quotient bit for both axis deltas of a ray.
`timescale 1ns / 1ps
module ddg_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               num_bit,
    input  ddg_pkg::div_cell_t cell_in,
    output ddg_pkg::div_cell_t cell_out
);
    import ddg_pkg::*;

    logic             valid_reg;
    div_cell_t        data_reg;
    div_cell_t        data_next;
    logic [15:0]      dvs_x, dvs_y;
    logic [REM_W:0]   sh_x, sh_y;
    logic             ge_x, ge_y;

    // Shift in the next numerator bit and try a subtract on each axis
    always_comb
    begin
        dvs_x = div_mag(cell_in.ray.dir_x);
        dvs_y = div_mag(cell_in.ray.dir_y);
        sh_x  = {cell_in.rem_x, num_bit};
        sh_y  = {cell_in.rem_y, num_bit};
        ge_x  = (sh_x >= {1'b0, dvs_x});
        ge_y  = (sh_y >= {1'b0, dvs_y});
        data_next       = cell_in;
        data_next.rem_x = ge_x ? REM_W'(sh_x - {1'b0, dvs_x}) : REM_W'(sh_x);
        data_next.rem_y = ge_y ? REM_W'(sh_y - {1'b0, dvs_y}) : REM_W'(sh_y);
        data_next.quo_x = {cell_in.quo_x[QUO_W-2:0], ge_x};
        data_next.quo_y = {cell_in.quo_y[QUO_W-2:0], ge_y};
    end

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cell_in.valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

[sv/ddg_step_unit.sv]
// Step unit: side-distance setup, the DDA walk and the hit/texture pipeline.
`timescale 1ns / 1ps
module ddg_step_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  ddg_pkg::div_cell_t div_in,
    output logic               slot_full,
    output logic               result_valid,
    output ddg_pkg::result_t   result
);
    import ddg_pkg::*;

    // Setup slot
    logic               slot_reg;
    ray_t               s_ray_reg;
    logic [QUO_W-1:0]   s_ddx_reg, s_ddy_reg;
    logic [31:0]        s_px_reg, s_py_reg;
    logic [10:0]        frac_x, frac_y;

    // Walker
    logic               run_reg;
    logic [STEP_W-1:0]  cnt_reg;
    ray_t               w_ray_reg;
    logic [SD_W-1:0]    sdx_reg, sdy_reg, ddx_reg, ddy_reg;
    logic signed [11:0] cx_reg, cy_reg;
    logic               w_last, load, x_step;

    // Stage A
    logic               a_valid_reg, a_last_reg, a_xstep_reg, a_neg_reg;
    logic [DIST_W-1:0]  a_dist_reg;
    logic signed [11:0] a_cx_reg, a_cy_reg;
    logic signed [15:0] a_d_reg;
    logic [19:0]        a_s_reg;

    // Stage B
    logic               b_valid_reg, b_last_reg, b_xstep_reg, b_neg_reg;
    logic [DIST_W-1:0]  b_dist_reg;
    logic signed [11:0] b_cx_reg, b_cy_reg;
    logic signed [PROD_W-1:0] b_prod_reg;
    logic [19:0]        b_s_reg;

    // Stage C
    logic signed [PROD_W-1:0] q_full;
    logic [31:0]        other, line_pos, ux, uy;
    logic signed [11:0] line_cell;
    result_t            res_next, res_reg;
    logic               res_valid_reg;

    assign w_last    = (cnt_reg == STEP_W'(STEPS - 1));
    assign load      = slot_reg && (!run_reg || w_last);
    assign x_step    = (sdx_reg < sdy_reg);
    assign slot_full = slot_reg;

    // Distance from origin to first line, per axis
    always_comb
    begin
        frac_x = (div_in.ray.dir_x < 16'sd0) ? {1'b0, div_in.ray.start_x[9:0]}
                                             : 11'd1024 - {1'b0, div_in.ray.start_x[9:0]};
        frac_y = (div_in.ray.dir_y < 16'sd0) ? {1'b0, div_in.ray.start_y[9:0]}
                                             : 11'd1024 - {1'b0, div_in.ray.start_y[9:0]};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 1'b0;
            run_reg       <= 1'b0;
            cnt_reg       <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (div_in.valid)
                slot_reg <= 1'b1;
            else if (load)
                slot_reg <= 1'b0;
            if (load)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                run_reg <= !w_last;
                cnt_reg <= cnt_reg + STEP_W'(1);
            end
            a_valid_reg   <= run_reg;
            b_valid_reg   <= a_valid_reg;
            res_valid_reg <= b_valid_reg;
        end
    end

    // Hold setup products for the next ray
    always_ff @(posedge clk)
    begin
        if (div_in.valid)
        begin
            s_ray_reg <= div_in.ray;
            s_ddx_reg <= div_in.quo_x;
            s_ddy_reg <= div_in.quo_y;
            s_px_reg  <= 32'(frac_x * div_in.quo_x);
            s_py_reg  <= 32'(frac_y * div_in.quo_y);
        end
    end

    // Walk: load a new ray or take one grid step
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_ray_reg <= s_ray_reg;
            ddx_reg   <= SD_W'(s_ddx_reg);
            ddy_reg   <= SD_W'(s_ddy_reg);
            sdx_reg   <= SD_W'(s_px_reg[31:SQ_SHIFT]);
            sdy_reg   <= SD_W'(s_py_reg[31:SQ_SHIFT]);
            cx_reg    <= {2'b00, s_ray_reg.start_x[19:10]};
            cy_reg    <= {2'b00, s_ray_reg.start_y[19:10]};
        end
        else if (run_reg)
        begin
            if (x_step)
            begin
                sdx_reg <= sdx_reg + ddx_reg;
                cx_reg  <= (w_ray_reg.dir_x < 16'sd0) ? cx_reg - 12'sd1 : cx_reg + 12'sd1;
            end
            else
            begin
                sdy_reg <= sdy_reg + ddy_reg;
                cy_reg  <= (w_ray_reg.dir_y < 16'sd0) ? cy_reg - 12'sd1 : cy_reg + 12'sd1;
            end
        end
    end

    // Stage A: capture the crossing
    always_ff @(posedge clk)
    begin
        a_last_reg  <= w_last;
        a_xstep_reg <= x_step;
        if (x_step)
        begin
            a_neg_reg  <= (w_ray_reg.dir_x < 16'sd0);
            a_dist_reg <= DIST_W'(sdx_reg);
            a_cx_reg   <= (w_ray_reg.dir_x < 16'sd0) ? cx_reg - 12'sd1 : cx_reg + 12'sd1;
            a_cy_reg   <= cy_reg;
            a_d_reg    <= w_ray_reg.dir_y;
            a_s_reg    <= w_ray_reg.start_y;
        end
        else
        begin
            a_neg_reg  <= (w_ray_reg.dir_y < 16'sd0);
            a_dist_reg <= DIST_W'(sdy_reg);
            a_cx_reg   <= cx_reg;
            a_cy_reg   <= (w_ray_reg.dir_y < 16'sd0) ? cy_reg - 12'sd1 : cy_reg + 12'sd1;
            a_d_reg    <= w_ray_reg.dir_x;
            a_s_reg    <= w_ray_reg.start_x;
        end
    end

    // Stage B: distance times the other direction
    always_ff @(posedge clk)
    begin
        b_last_reg  <= a_last_reg;
        b_xstep_reg <= a_xstep_reg;
        b_neg_reg   <= a_neg_reg;
        b_dist_reg  <= a_dist_reg;
        b_cx_reg    <= a_cx_reg;
        b_cy_reg    <= a_cy_reg;
        b_s_reg     <= a_s_reg;
        b_prod_reg  <= $signed({1'b0, a_dist_reg}) * a_d_reg;
    end

    // Stage C: hit point, face and texture coordinate
    always_comb
    begin
        q_full    = (b_prod_reg + (b_prod_reg[PROD_W-1] ? PROD_W'(1023) : '0)) >>> SQ_SHIFT;
        other     = {12'd0, b_s_reg} + q_full[31:0];
        line_cell = b_xstep_reg ? b_cx_reg : b_cy_reg;
        line_pos  = {{10{line_cell[11]}}, line_cell, 10'd0} + (b_neg_reg ? 32'd1024 : 32'd0);
        ux        = b_xstep_reg ? line_pos : other;
        uy        = b_xstep_reg ? other : line_pos;
        res_next.cell_x   = b_cx_reg;
        res_next.cell_y   = b_cy_reg;
        res_next.distance = b_dist_reg[25:0];
        res_next.hit_x    = ux;
        res_next.hit_y    = uy;
        res_next.last     = b_last_reg;
        if (b_xstep_reg)
            res_next.face = b_neg_reg ? FACE_X_NEG : FACE_X_POS;
        else
            res_next.face = b_neg_reg ? FACE_Y_NEG : FACE_Y_POS;
        case (res_next.face)
            FACE_Y_NEG: res_next.tex_coord = ux[9:0];
            FACE_X_NEG: res_next.tex_coord = 10'(-uy[9:0]);
            FACE_Y_POS: res_next.tex_coord = 10'(-ux[9:0]);
            default:    res_next.tex_coord = uy[9:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

[sv/dda_grid_ray_walk_core.sv]
// Top level: divider cell chain feeding the DDA step unit.
`timescale 1ns / 1ps
// A ray is taken when start is high and busy is low. The two per-square deltas
// (2^20 over each direction magnitude) come from a chain of 21 divider cells,
// one quotient bit per cell per cycle, and wait in a setup slot; the walker
// then emits MAX_STEPS results on consecutive cycles, result_valid high for one
// cycle each, each step passing through stages A and B and the result register.
// While one ray walks the next one divides. Results cannot be held
// off; the receiver must take every beat as it appears.
module dda_grid_ray_walk_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ddg_pkg::ray_t    ray,
    output logic             result_valid,
    output ddg_pkg::result_t result
);
    import ddg_pkg::*;

    div_cell_t              link [DIV_CELLS+1];
    logic [DIV_CELLS-1:0]   occ;
    logic                   slot_full;

    // Feed the chain head
    always_comb
    begin
        link[0].valid = start && !busy;
        link[0].ray   = ray;
        link[0].rem_x = '0;
        link[0].rem_y = '0;
        link[0].quo_x = '0;
        link[0].quo_y = '0;
    end

    // Numerator is 2^20: only the first cell shifts in a one
    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_cell
        ddg_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .num_bit  (k == 0),
            .cell_in  (link[k]),
            .cell_out (link[k+1])
        );
        assign occ[k] = link[k+1].valid;
    end

    ddg_step_unit u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .div_in       (link[DIV_CELLS]),
        .slot_full    (slot_full),
        .result_valid (result_valid),
        .result       (result)
    );

    // Hold off new rays while one divides or waits for the walker
    assign busy = (|occ) || slot_full;

endmodule

[sv/ddg_checker.sv]
// Checker: port-level properties of the ray walk core, bound to the top level.
`timescale 1ns / 1ps
module ddg_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input ddg_pkg::ray_t    ray,
    input logic             result_valid,
    input ddg_pkg::result_t result
);
    import ddg_pkg::*;

    // A taken ray blocks the next one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a ray was taken");

    // An x crossing lies on a vertical grid line
    a_x_on_line: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.face == FACE_X_POS || result.face == FACE_X_NEG))
        |-> (result.hit_x[9:0] == 10'd0))
        else $error("x crossing off grid line");

    // A y crossing lies on a horizontal grid line
    a_y_on_line: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.face == FACE_Y_POS || result.face == FACE_Y_NEG))
        |-> (result.hit_y[9:0] == 10'd0))
        else $error("y crossing off grid line");

    // Positive x face textures straight from hit_y
    a_tex_x_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.face == FACE_X_POS) |-> (result.tex_coord == result.hit_y[9:0]))
        else $error("texture coordinate mismatch on positive x face");

endmodule

bind dda_grid_ray_walk_core ddg_checker u_ddg_checker (.*);
